[rtl/qs_pkg.sv]
// ----------------------------------------------------------------------------
// qs_pkg: shared constants for the quaternion slerp pipeline
// CORDIC datapath widths, square root depth and the arctangent table.
// ----------------------------------------------------------------------------
package qs_pkg;

    // CORDIC x/y/z width: Q30 values with gain and sign headroom
    localparam int CW  = 34;
    // sine width after the Q30 -> Q28 step
    localparam int SW  = 32;
    // result bits of the square root of a 61-bit radicand
    localparam int SQN = 31;

    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    // atan(2^-i) in Q30, rounded to nearest
    function automatic logic signed [CW-1:0] atan_q30(input int i);
        logic signed [CW-1:0] v;
        case (i)
            0:       v = CW'(843314857);
            1:       v = CW'(497837829);
            2:       v = CW'(263043837);
            3:       v = CW'(133525159);
            4:       v = CW'(67021687);
            5:       v = CW'(33543516);
            6:       v = CW'(16775851);
            7:       v = CW'(8388437);
            8:       v = CW'(4194283);
            9:       v = CW'(2097149);
            default: v = (i <= 30) ? (CW'(1) << (30 - i)) : '0;
        endcase
        return v;
    endfunction

endpackage

[rtl/qs_req_if.sv]
// ----------------------------------------------------------------------------
// qs_req_if: slerp request channel
// Two quaternions and an interpolation fraction, valid/ready handshake.
// ----------------------------------------------------------------------------
interface qs_req_if #(
    parameter int COMPONENT_BITS = 16
);
    logic                             valid;
    logic                             ready;
    logic signed [COMPONENT_BITS-1:0] from_qx;
    logic signed [COMPONENT_BITS-1:0] from_qy;
    logic signed [COMPONENT_BITS-1:0] from_qz;
    logic signed [COMPONENT_BITS-1:0] from_qw;
    logic signed [COMPONENT_BITS-1:0] to_qx;
    logic signed [COMPONENT_BITS-1:0] to_qy;
    logic signed [COMPONENT_BITS-1:0] to_qz;
    logic signed [COMPONENT_BITS-1:0] to_qw;
    logic        [COMPONENT_BITS-1:0] fraction;

    modport source (
        output valid, from_qx, from_qy, from_qz, from_qw,
        output to_qx, to_qy, to_qz, to_qw, fraction,
        input  ready
    );
    modport sink (
        input  valid, from_qx, from_qy, from_qz, from_qw,
        input  to_qx, to_qy, to_qz, to_qw, fraction,
        output ready
    );
endinterface

[rtl/qs_rsp_if.sv]
// ----------------------------------------------------------------------------
// qs_rsp_if: slerp result channel
// Interpolated quaternion and the start-copy flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface qs_rsp_if #(
    parameter int COMPONENT_BITS = 16
);
    logic                             valid;
    logic                             ready;
    logic signed [COMPONENT_BITS-1:0] out_qx;
    logic signed [COMPONENT_BITS-1:0] out_qy;
    logic signed [COMPONENT_BITS-1:0] out_qz;
    logic signed [COMPONENT_BITS-1:0] out_qw;
    logic                             copied_start;

    modport source (
        output valid, out_qx, out_qy, out_qz, out_qw, copied_start,
        input  ready
    );
    modport sink (
        input  valid, out_qx, out_qy, out_qz, out_qw, copied_start,
        output ready
    );
endinterface

[rtl/quaternion_slerp.sv]
// ----------------------------------------------------------------------------
// quaternion_slerp: pipelined spherical linear interpolation
// Dot product, square root, CORDIC angle, three CORDIC sines, weighted sum
// and a bit-per-stage divider, all in one stall-together pipeline.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  i_req   | in  | valid/ready        | from_q*, to_q*, fraction
//  o_rsp   | out | valid/ready        | out_q*, copied_start
//
//  One item enters per cycle while the result register is not held; the depth
//  is set by the 31-step square root, the two CORDIC chains and the divider
//  that yields one quotient bit per stage.
//  Reset clears only the valid bits. When the result register is held, the
//  whole pipeline holds and i_req.ready drops.
// ----------------------------------------------------------------------------
module quaternion_slerp #(
    parameter int COMPONENT_BITS = 16,
    parameter int TRIG_STAGES    = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    qs_req_if.sink   i_req,
    qs_rsp_if.source o_rsp
);
    import qs_pkg::*;

    localparam int CB   = COMPONENT_BITS;
    localparam int TS   = TRIG_STAGES;
    localparam int TF   = CB - 1;
    localparam int DROP = (CB > 30) ? 2 : 0;
    localparam int SUMW = 2 * CB + 1;
    localparam int K    = 2 * (CB - 2) - DROP - 30;
    localparam int KR   = (K >= 0) ? K : 0;
    localparam int KL   = (K < 0) ? -K : 0;
    localparam int DQW  = SUMW + KL;
    localparam int PMW  = CB + SW;
    localparam int NMW  = CB + SW + 1;
    localparam int DVW  = CB + 33;

    // pipeline positions
    localparam int PDOT = 3;
    localparam int PSQ  = 4 + SQN;
    localparam int PANG = PSQ + TS + 1;
    localparam int PROT = PANG + TS;
    localparam int PSIN = PROT + 1;
    localparam int PMUL = PSIN + 1;
    localparam int PNUM = PMUL + 1;
    localparam int PDD  = PNUM + 1;
    localparam int POVF = PDD + 1;
    localparam int LAT  = POVF + CB + 2;

    localparam logic [CB-1:0] T_ONE = {1'b1, {(CB-1){1'b0}}};
    localparam logic [CB:0]   HALFQ = (CB+1)'(1) << (CB - 1);
    localparam logic [CB:0]   MAXQ  = HALFQ - 1'b1;
    localparam logic [CB-1:0] S_MIN = {1'b1, {(CB-1){1'b0}}};
    localparam logic [CB-1:0] S_MAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CW-1:0] TINY = CW'(64'd1 << (32 - CB));
    localparam logic signed [CW-1:0] X0   = CW'(ONE_Q30);

    typedef struct packed {
        logic [3:0][CB-1:0] f;
        logic [3:0][CB-1:0] g;
        logic [CB-1:0]      t;
        logic               dneg;
        logic               copy;
    } t_ctx;

    logic         adv;
    logic [LAT:1] r_vld;
    t_ctx         r_ctx [1:LAT-1];
    t_ctx         w_in_ctx;

    assign adv         = !r_vld[LAT] || o_rsp.ready;
    assign i_req.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[LAT-1:1], i_req.valid};
        end
    end

    always_comb begin
        w_in_ctx.f[0] = i_req.from_qx;
        w_in_ctx.f[1] = i_req.from_qy;
        w_in_ctx.f[2] = i_req.from_qz;
        w_in_ctx.f[3] = i_req.from_qw;
        w_in_ctx.g[0] = i_req.to_qx;
        w_in_ctx.g[1] = i_req.to_qy;
        w_in_ctx.g[2] = i_req.to_qz;
        w_in_ctx.g[3] = i_req.to_qw;
        w_in_ctx.t    = (i_req.fraction > T_ONE) ? T_ONE : i_req.fraction;
        w_in_ctx.dneg = 1'b0;
        w_in_ctx.copy = 1'b0;
    end

    // ---------------- dot product ----------------
    logic signed [2*CB-1:0] r_prod [0:3];
    logic [SUMW-1:0]        r_pos, r_neg, w_pos, w_neg, w_diff;
    logic [DQW-1:0]         w_dqw;
    logic                   w_dneg, w_copy;
    logic [29:0]            r_dq;

    always_comb begin
        logic [2*CB-1:0] mag;
        w_pos = '0;
        w_neg = '0;
        for (int c = 0; c < 4; c++) begin
            mag = r_prod[c][2*CB-1] ? (2*CB)'(-r_prod[c]) : r_prod[c];
            mag = mag >> DROP;
            if (r_prod[c][2*CB-1]) begin
                w_neg = w_neg + SUMW'(mag);
            end else begin
                w_pos = w_pos + SUMW'(mag);
            end
        end
    end

    assign w_dneg = r_neg > r_pos;
    assign w_diff = w_dneg ? (r_neg - r_pos) : (r_pos - r_neg);
    assign w_dqw  = (DQW'(w_diff) >> KR) << KL;
    assign w_copy = w_dqw >= DQW'(ONE_Q30 - 64'd1);

    // ---------------- square root of 1 - dot^2 ----------------
    logic [61:0] r_sq_v  [0:SQN];
    logic [61:0] r_sq_r  [0:SQN];
    logic [29:0] r_sq_dq [0:SQN];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int c = 0; c < 4; c++) begin
                r_prod[c] <= $signed(w_in_ctx.f[c]) * $signed(w_in_ctx.g[c]);
            end
            r_pos      <= w_pos;
            r_neg      <= w_neg;
            r_dq       <= w_dqw[29:0];
            r_sq_v[0]  <= (62'd1 << 60) - ({32'd0, r_dq} * {32'd0, r_dq});
            r_sq_r[0]  <= '0;
            r_sq_dq[0] <= r_dq;
        end
    end

    for (genvar j = 0; j < SQN; j++) begin : g_sqrt
        localparam logic [61:0] BIT = 62'd1 << (60 - 2 * j);
        logic [61:0] rb;
        assign rb = r_sq_r[j] + BIT;
        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (r_sq_v[j] >= rb) begin
                    r_sq_v[j+1] <= r_sq_v[j] - rb;
                    r_sq_r[j+1] <= (r_sq_r[j] >> 1) + BIT;
                end else begin
                    r_sq_v[j+1] <= r_sq_v[j];
                    r_sq_r[j+1] <= r_sq_r[j] >> 1;
                end
                r_sq_dq[j+1] <= r_sq_dq[j];
            end
        end
    end

    // ---------------- CORDIC vectoring: theta ----------------
    logic signed [CW-1:0] r_vx [1:TS];
    logic signed [CW-1:0] r_vy [1:TS];
    logic signed [CW-1:0] r_vz [1:TS];

    for (genvar i = 0; i < TS; i++) begin : g_vec
        logic signed [CW-1:0] x, y, z;
        if (i == 0) begin : g_src
            assign x = CW'(r_sq_dq[SQN]);
            assign y = CW'(r_sq_r[SQN][30:0]);
            assign z = '0;
        end else begin : g_src
            assign x = r_vx[i];
            assign y = r_vy[i];
            assign z = r_vz[i];
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (y >= 0) begin
                    r_vx[i+1] <= x + (y >>> i);
                    r_vy[i+1] <= y - (x >>> i);
                    r_vz[i+1] <= z + atan_q30(i);
                end else begin
                    r_vx[i+1] <= x - (y >>> i);
                    r_vy[i+1] <= y + (x >>> i);
                    r_vz[i+1] <= z - atan_q30(i);
                end
            end
        end
    end

    // ---------------- split angles ----------------
    logic signed [CW-1:0] w_theta;
    logic [CB-1:0]        w_omt;
    logic [CB+31:0]       w_p0, w_p1;
    logic                 w_tiny;
    logic signed [CW-1:0] r_ang [0:2];

    assign w_theta = r_vz[TS];
    assign w_tiny  = w_theta < TINY;
    assign w_omt   = T_ONE - r_ctx[PANG-1].t;
    assign w_p0    = (CB+32)'(w_theta[31:0]) * (CB+32)'(w_omt);
    assign w_p1    = (CB+32)'(w_theta[31:0]) * (CB+32)'(r_ctx[PANG-1].t);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ang[0] <= w_theta;
            r_ang[1] <= CW'(w_p0[TF+31:TF]);
            r_ang[2] <= CW'(w_p1[TF+31:TF]);
        end
    end

    // ---------------- CORDIC rotation: three sines ----------------
    logic signed [CW-1:0] r_rx [0:2][1:TS];
    logic signed [CW-1:0] r_ry [0:2][1:TS];
    logic signed [CW-1:0] r_rz [0:2][1:TS];

    for (genvar k = 0; k < 3; k++) begin : g_lane
        for (genvar i = 0; i < TS; i++) begin : g_rot
            logic signed [CW-1:0] x, y, z;
            if (i == 0) begin : g_src
                assign x = X0;
                assign y = '0;
                assign z = r_ang[k];
            end else begin : g_src
                assign x = r_rx[k][i];
                assign y = r_ry[k][i];
                assign z = r_rz[k][i];
            end
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    if (z >= 0) begin
                        r_rx[k][i+1] <= x - (y >>> i);
                        r_ry[k][i+1] <= y + (x >>> i);
                        r_rz[k][i+1] <= z - atan_q30(i);
                    end else begin
                        r_rx[k][i+1] <= x + (y >>> i);
                        r_ry[k][i+1] <= y - (x >>> i);
                        r_rz[k][i+1] <= z + atan_q30(i);
                    end
                end
            end
        end
    end

    // ---------------- weights and numerators ----------------
    logic signed [SW-1:0]  w_s [0:2];
    logic                  w_sth_bad;
    logic signed [SW-1:0]  r_sth, r_s0, r_s1, r_sth_m, r_sth_n, r_sth_d;
    logic signed [PMW-1:0] r_pf [0:3];
    logic signed [PMW-1:0] r_pg [0:3];
    logic signed [NMW-1:0] r_num [0:3];
    logic [DVW-1:0]        r_dd [0:3];
    logic                  r_sg [0:3];
    logic signed [NMW-1:0] w_half;

    for (genvar k = 0; k < 3; k++) begin : g_sine
        logic signed [CW-1:0] ys;
        assign ys     = r_ry[k][TS] >>> 2;
        assign w_s[k] = SW'(ys);
    end
    assign w_sth_bad = w_s[0] <= 0;
    assign w_half    = NMW'(r_sth_n >>> 1);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sth <= w_s[0];
            r_s0  <= w_s[1];
            r_s1  <= r_ctx[PSIN-1].dneg ? -w_s[2] : w_s[2];
            r_sth_m <= r_sth;
            r_sth_n <= r_sth_m;
            r_sth_d <= r_sth_n;
            for (int c = 0; c < 4; c++) begin
                r_pf[c]  <= $signed(r_ctx[PMUL-1].f[c]) * r_s0;
                r_pg[c]  <= $signed(r_ctx[PMUL-1].g[c]) * r_s1;
                r_num[c] <= NMW'(r_pf[c]) + NMW'(r_pg[c]);
                // round half away from zero on the magnitude
                r_dd[c]  <= (r_num[c] < 0) ? DVW'(w_half - r_num[c])
                                           : DVW'(r_num[c] + w_half);
                r_sg[c]  <= r_num[c] < 0;
            end
        end
    end

    // ---------------- divider, one quotient bit per stage ----------------
    logic [DVW-1:0] r_dv_rem [0:3][0:CB+1];
    logic [CB:0]    r_dv_q   [0:3][0:CB+1];
    logic           r_dv_ovf [0:3][0:CB+1];
    logic           r_dv_sg  [0:3][0:CB+1];
    logic [DVW-1:0] r_dv_sth [0:CB+1];
    logic [DVW-1:0] w_sth_u;

    assign w_sth_u = DVW'($unsigned(r_sth_d));

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dv_sth[0] <= w_sth_u;
            for (int c = 0; c < 4; c++) begin
                r_dv_rem[c][0] <= r_dd[c];
                r_dv_q[c][0]   <= '0;
                r_dv_ovf[c][0] <= r_dd[c] >= (w_sth_u << (CB + 1));
                r_dv_sg[c][0]  <= r_sg[c];
            end
        end
    end

    for (genvar j = 0; j <= CB; j++) begin : g_div
        localparam int B = CB - j;
        logic [DVW-1:0] d;
        assign d = r_dv_sth[j] << B;
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dv_sth[j+1] <= r_dv_sth[j];
                for (int c = 0; c < 4; c++) begin
                    if (r_dv_rem[c][j] >= d) begin
                        r_dv_rem[c][j+1] <= r_dv_rem[c][j] - d;
                        r_dv_q[c][j+1]   <= r_dv_q[c][j] | ((CB+1)'(1) << B);
                    end else begin
                        r_dv_rem[c][j+1] <= r_dv_rem[c][j];
                        r_dv_q[c][j+1]   <= r_dv_q[c][j];
                    end
                    r_dv_ovf[c][j+1] <= r_dv_ovf[c][j];
                    r_dv_sg[c][j+1]  <= r_dv_sg[c][j];
                end
            end
        end
    end

    // ---------------- context line ----------------
    for (genvar p = 1; p < LAT; p++) begin : g_ctx
        t_ctx src, n_ctx;
        if (p == 1) begin : g_src
            assign src = w_in_ctx;
        end else begin : g_src
            assign src = r_ctx[p-1];
        end
        always_comb begin
            n_ctx = src;
            if (p == PDOT) begin
                n_ctx.dneg = w_dneg;
                n_ctx.copy = w_copy;
            end
            if (p == PANG) begin
                n_ctx.copy = src.copy | w_tiny;
            end
            if (p == PSIN) begin
                n_ctx.copy = src.copy | w_sth_bad;
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_ctx[p] <= n_ctx;
            end
        end
    end

    // ---------------- saturate and select ----------------
    logic [CB-1:0] r_oq [0:3];
    logic          r_ocopy;
    logic [CB-1:0] n_oq [0:3];

    always_comb begin
        logic [CB:0] q;
        for (int c = 0; c < 4; c++) begin
            q = r_dv_q[c][CB+1];
            if (r_ctx[LAT-1].copy) begin
                n_oq[c] = r_ctx[LAT-1].f[c];
            end else if (r_dv_sg[c][CB+1]) begin
                n_oq[c] = (r_dv_ovf[c][CB+1] || q > HALFQ) ? S_MIN : CB'(~q + 1'b1);
            end else begin
                n_oq[c] = (r_dv_ovf[c][CB+1] || q > MAXQ) ? S_MAX : CB'(q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int c = 0; c < 4; c++) begin
                r_oq[c] <= n_oq[c];
            end
            r_ocopy <= r_ctx[LAT-1].copy;
        end
    end

    assign o_rsp.valid        = r_vld[LAT];
    assign o_rsp.out_qx       = r_oq[0];
    assign o_rsp.out_qy       = r_oq[1];
    assign o_rsp.out_qz       = r_oq[2];
    assign o_rsp.out_qw       = r_oq[3];
    assign o_rsp.copied_start = r_ocopy;

    // ---------------- assertions ----------------
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[LAT] |-> i_req.ready)
        else $error("request stalled with an empty result register");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> r_vld[1])
        else $error("accepted request missing from first stage");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    a_fraction_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (r_ctx[1].t <= T_ONE))
        else $error("fraction not saturated to one");

endmodule
